/* rtl/fcr_pkg.sv */
// fcr_pkg: shared types and constants for the first-match rule classifier.
// Used by fcr_rule_cmp and first_match_packet_rule_classifier_top.
package fcr_pkg;

  localparam int NUM_RULES_DEF = 32;
  localparam int RID_W         = 6;

  localparam logic [7:0] IPNUM_TCP = 8'd6;
  localparam logic [7:0] IPNUM_UDP = 8'd17;

  // command codes
  localparam logic [1:0] CMD_MATCH  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_NO_RULE = 2'd2;

  // present mask bit positions
  localparam int PRES_PROTO = 0;
  localparam int PRES_SIP   = 1;
  localparam int PRES_SPORT = 2;
  localparam int PRES_DIP   = 3;
  localparam int PRES_DPORT = 4;

  typedef struct packed {
    logic [7:0]  proto;
    logic [4:0]  pres;
    logic        blk;
    logic        dir;
    logic [31:0] src_mask;
    logic [31:0] src_ip;
    logic [31:0] dst_mask;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
    logic [15:0] src_port;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  typedef struct packed {
    logic        dir;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
  } pkt_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             drop;
    logic             matched;
    logic [RID_W-1:0] rid;
  } res_t;

endpackage

/* rtl/fcr_ram.sv */
// fcr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/fcr_rule_cmp.sv */
// fcr_rule_cmp: compares one stored rule against a packet header.
// Depends on fcr_pkg (rule_t, pkt_t, protocol and present-bit constants).
module fcr_rule_cmp (
  input  fcr_pkg::rule_t rule,
  input  fcr_pkg::pkt_t  pkt,
  output logic           hit
);

  logic port_proto;
  logic proto_ok;
  logic sip_ok;
  logic dip_ok;
  logic sport_ok;
  logic dport_ok;

  // zero mask means exact compare, not wildcard
  function automatic logic addr_hit(input logic [31:0] ip, input logic [31:0] mask,
                                    input logic [31:0] pa);
    logic r;
    if (mask == 32'd0) begin
      r = (ip == pa);
    end else begin
      r = ((ip & mask) == (pa & mask));
    end
    return r;
  endfunction

  always_comb begin
    port_proto = (pkt.proto == fcr_pkg::IPNUM_TCP) || (pkt.proto == fcr_pkg::IPNUM_UDP);
    proto_ok   = !rule.pres[fcr_pkg::PRES_PROTO] || (rule.proto == pkt.proto);
    sip_ok     = !rule.pres[fcr_pkg::PRES_SIP] ||
                 addr_hit(rule.src_ip, rule.src_mask, pkt.src_ip);
    dip_ok     = !rule.pres[fcr_pkg::PRES_DIP] ||
                 addr_hit(rule.dst_ip, rule.dst_mask, pkt.dst_ip);
    sport_ok   = !rule.pres[fcr_pkg::PRES_SPORT] || !port_proto ||
                 (rule.src_port == pkt.src_port);
    dport_ok   = !rule.pres[fcr_pkg::PRES_DPORT] || !port_proto ||
                 (rule.dst_port == pkt.dst_port);
    hit = (rule.dir == pkt.dir) && proto_ok && sip_ok && dip_ok && sport_ok && dport_ok;
  end

endmodule

/* rtl/first_match_packet_rule_classifier_top.sv */
// first_match_packet_rule_classifier_top: rule table with insert, delete and first-match scan.
// Depends on fcr_pkg, fcr_ram (rule store) and fcr_rule_cmp (per-rule compare).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in_     | in_valid/in_ready, command and rule/packet | input
//  out_    | out_valid/out_ready, status and verdict    | output
//
// Match: reads one rule per cycle in slot order and stops at the first hit;
// a scan that finds no rule reads every slot before reporting.
// Insert: walks the valid bits for the lowest free slot.
// Delete and unused commands go straight to the result state.
// Reset clears the valid bits (flip-flops); the rule store itself needs no clearing.
// A result waiting at the output does not block the next input transfer; the block
// stalls only if a second result is ready before the first one is taken.
module first_match_packet_rule_classifier_top #(
  parameter int NUM_RULES = fcr_pkg::NUM_RULES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_direction,
  input  logic        in_block_action,
  input  logic [4:0]  in_present_mask,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_ip,
  input  logic [31:0] in_src_mask,
  input  logic [15:0] in_src_port,
  input  logic [31:0] in_dst_ip,
  input  logic [31:0] in_dst_mask,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_rule_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_drop,
  output logic        out_matched,
  output logic [5:0]  out_result_rule_id
);

  localparam int SLOT_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int CNT_W  = $clog2(NUM_RULES + 1);
  localparam int RID_W  = fcr_pkg::RID_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_INS   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]    chk_slot_r, chk_slot_nxt;
  logic [NUM_RULES-1:0] valid_r, valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fcr_pkg::res_t        out_res_r, out_res_nxt;
  fcr_pkg::res_t        res_r, res_nxt;
  fcr_pkg::pkt_t        pkt_r, pkt_nxt;
  fcr_pkg::rule_t       wrule_r, wrule_nxt;

  fcr_pkg::rule_t       rd_rule;
  logic                 ram_we;
  logic                 ram_re;
  logic                 cmp_hit;
  logic                 hit_now;
  logic [SLOT_W-1:0]    scan_slot;
  logic [7:0]           del_idx8;
  logic [SLOT_W-1:0]    del_slot;
  logic                 del_ok;
  logic                 scan_end;

  fcr_ram #(
    .WIDTH (fcr_pkg::RULE_W),
    .DEPTH (NUM_RULES),
    .AW    (SLOT_W)
  ) u_rule_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (scan_slot),
    .wr_data (wrule_r),
    .rd_en   (ram_re),
    .rd_addr (scan_slot),
    .rd_data (rd_rule)
  );

  fcr_rule_cmp u_cmp (
    .rule (rd_rule),
    .pkt  (pkt_r),
    .hit  (cmp_hit)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign scan_slot = scan_r[SLOT_W-1:0];
  assign scan_end  = (scan_r == CNT_W'(NUM_RULES));
  assign del_idx8  = in_rule_id - 8'd1;
  assign del_slot  = del_idx8[SLOT_W-1:0];
  assign del_ok    = (in_rule_id != 8'd0) && (in_rule_id <= 8'(NUM_RULES)) &&
                     valid_r[del_slot];
  assign hit_now   = chk_vld_r && valid_r[chk_slot_r] && cmp_hit;

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    chk_vld_nxt   = chk_vld_r;
    chk_slot_nxt  = chk_slot_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    pkt_nxt       = pkt_r;
    wrule_nxt     = wrule_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pkt_nxt   = '{dir: in_direction, proto: in_protocol, src_ip: in_src_ip,
                        src_port: in_src_port, dst_ip: in_dst_ip, dst_port: in_dst_port};
          wrule_nxt = '{proto: in_protocol, pres: in_present_mask, blk: in_block_action,
                        dir: in_direction, src_mask: in_src_mask, src_ip: in_src_ip,
                        dst_mask: in_dst_mask, dst_ip: in_dst_ip,
                        dst_port: in_dst_port, src_port: in_src_port};
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          res_nxt     = '0;
          unique case (in_cmd)
            fcr_pkg::CMD_MATCH:  state_nxt = ST_MATCH;
            fcr_pkg::CMD_INSERT: state_nxt = ST_INS;
            fcr_pkg::CMD_DELETE: begin
              if (del_ok) begin
                valid_nxt[del_slot] = 1'b0;
              end else begin
                res_nxt.status = fcr_pkg::STS_NO_RULE;
              end
              state_nxt = ST_FIN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MATCH: begin
        // read of slot s overlaps the compare of slot s-1
        if (hit_now) begin
          res_nxt.matched = 1'b1;
          res_nxt.drop    = rd_rule.blk;
          res_nxt.rid     = RID_W'({1'b0, chk_slot_r} + (SLOT_W + 1)'(1));
          state_nxt       = ST_FIN;
        end else if (scan_end && !chk_vld_r) begin
          state_nxt = ST_FIN;
        end else begin
          chk_vld_nxt  = !scan_end;
          chk_slot_nxt = scan_slot;
          if (!scan_end) begin
            ram_re   = 1'b1;
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end
      ST_INS: begin
        if (!valid_r[scan_slot]) begin
          ram_we               = 1'b1;
          valid_nxt[scan_slot] = 1'b1;
          res_nxt.rid          = RID_W'({1'b0, scan_slot} + (SLOT_W + 1)'(1));
          state_nxt            = ST_FIN;
        end else if (scan_r == CNT_W'(NUM_RULES - 1)) begin
          res_nxt.status = fcr_pkg::STS_FULL;
          state_nxt      = ST_FIN;
        end else begin
          scan_nxt = scan_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      chk_vld_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      chk_vld_r   <= chk_vld_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_slot_r <= chk_slot_nxt;
    out_res_r  <= out_res_nxt;
    res_r      <= res_nxt;
    pkt_r      <= pkt_nxt;
    wrule_r    <= wrule_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_drop           = out_res_r.drop;
  assign out_matched        = out_res_r.matched;
  assign out_result_rule_id = out_res_r.rid;

  // a drop verdict only comes from a matched rule
  a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.drop |-> out_res_r.matched)
    else $error("drop without matched rule");

  // table full always reports id 0
  a_full_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == fcr_pkg::STS_FULL |-> out_res_r.rid == '0)
    else $error("full status with nonzero id");

  // a successful insert adds exactly one valid rule
  a_insert_sets_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS && !valid_r[scan_slot] |=>
      $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("insert did not set one valid bit");

  // scan counter never runs past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MATCH |-> scan_r <= CNT_W'(NUM_RULES))
    else $error("scan counter out of range");

endmodule
